### design/base64_stream_encoder_assert.svh
// Assertion macros for the Base64 stream encoder checker.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied
`define B64E_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is applied
`define B64E_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/b64e_pkg.sv
// Shared types, constants and the alphabet function for the Base64 encoder.
// No dependencies; imported by the queue, front end, back end and top level.
`timescale 1ns / 1ps

package b64e_pkg;

    localparam int CHAR_W            = 7;
    localparam int B64E_QUEUE_DEPTH  = 4;
    localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3d;

    // Position of the next byte within a 3-byte group
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } b64e_phase_t;

    // Up to four characters produced by one input byte
    typedef struct packed {
        logic [3:0][CHAR_W-1:0] chars;
        logic [1:0]             cnt_m1;
        logic                   last;
    } b64e_job_t;

    // Queue status seen by the front and back ends
    typedef struct packed {
        logic full;
        logic empty;
    } b64e_q_status_t;

    // Map a sextet to its character of the standard alphabet
    function automatic logic [CHAR_W-1:0] enc_char(input logic [5:0] sextet);
        logic [CHAR_W-1:0] s;
        s = CHAR_W'(sextet);
        if (sextet < 6'd26)
            return s + 7'd65;
        else if (sextet < 6'd52)
            return s + 7'd71;
        else if (sextet < 6'd62)
            return s - 7'd4;
        else if (sextet == 6'd62)
            return 7'd43;
        else
            return 7'd47;
    endfunction

endpackage

### design/b64e_queue.sv
// Short queue of character jobs between the front and back ends.
// Depends on b64e_pkg for the job and status types.
`timescale 1ns / 1ps

module b64e_queue #(
    parameter int Depth = b64e_pkg::B64E_QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  b64e_pkg::b64e_job_t        push_job,
    input  logic                       pop,
    output b64e_pkg::b64e_job_t        pop_job,
    output b64e_pkg::b64e_q_status_t   status
);
    import b64e_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    b64e_job_t         entries [Depth];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;

    // Store a job at the write pointer
    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_job;
    end

    // Advance pointers and the fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign pop_job      = entries[rd_ptr_reg];
    assign status.full  = (count_reg == CntW'(Depth));
    assign status.empty = (count_reg == '0);

endmodule

### design/b64e_front.sv
// Front end: accepts bytes, tracks the group phase and leftover bits, and
// builds a job of one to four characters. Depends on b64e_pkg.
`timescale 1ns / 1ps

module b64e_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] data_byte
    input  logic                       s_tlast,   // last_byte
    output logic                       push,
    output b64e_pkg::b64e_job_t        push_job,
    input  b64e_pkg::b64e_q_status_t   q_status
);
    import b64e_pkg::*;

    b64e_phase_t  phase_reg, phase_next;
    logic [3:0]   carry_reg, carry_next;
    logic [7:0]   b;

    assign b        = s_tdata;
    assign s_tready = !q_status.full;
    assign push     = s_tvalid && !q_status.full;

    // Next phase and leftover bits on each accepted byte
    always_comb
    begin
        phase_next = phase_reg;
        carry_next = carry_reg;
        if (push)
        begin
            unique case (phase_reg)
                PH_SECOND:
                begin
                    phase_next = PH_THIRD;
                    carry_next = b[3:0];
                end
                PH_THIRD:
                begin
                    phase_next = PH_FIRST;
                    carry_next = '0;
                end
                default:
                begin
                    phase_next = PH_SECOND;
                    carry_next = {2'b00, b[1:0]};
                end
            endcase
            if (s_tlast)
            begin
                phase_next = PH_FIRST;
                carry_next = '0;
            end
        end
    end

    // Build the character job for the current byte
    always_comb
    begin
        push_job.chars  = {4{PAD_CHAR}};
        push_job.last   = s_tlast;
        push_job.cnt_m1 = 2'd0;
        unique case (phase_reg)
            PH_SECOND:
            begin
                push_job.chars[0] = enc_char({carry_reg[1:0], b[7:4]});
                push_job.chars[1] = enc_char({b[3:0], 2'b00});
                push_job.cnt_m1   = s_tlast ? 2'd2 : 2'd0;
            end
            PH_THIRD:
            begin
                push_job.chars[0] = enc_char({carry_reg, b[7:6]});
                push_job.chars[1] = enc_char(b[5:0]);
                push_job.cnt_m1   = 2'd1;
            end
            default:
            begin
                push_job.chars[0] = enc_char(b[7:2]);
                push_job.chars[1] = enc_char({b[1:0], 4'b0000});
                push_job.cnt_m1   = s_tlast ? 2'd3 : 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            carry_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

### design/b64e_back.sv
// Back end: takes jobs from the queue and sends one character per transfer
// through a registered output stage. Depends on b64e_pkg.
`timescale 1ns / 1ps

module b64e_back (
    input  logic                       clk,
    input  logic                       rst_n,
    output logic                       pop,
    input  b64e_pkg::b64e_job_t        pop_job,
    input  b64e_pkg::b64e_q_status_t   q_status,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // [6:0] char_code, [7] zero
    output logic                       m_tlast    // last_char
);
    import b64e_pkg::*;

    logic                busy_reg, busy_next;
    b64e_job_t           job_reg, job_next;
    logic [1:0]          idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   out_char_reg, out_char_next;
    logic                out_last_reg, out_last_next;
    logic                advance, emit, job_done;

    // Move the output stage when it is empty or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign emit     = advance && busy_reg;
    assign job_done = emit && (idx_reg == job_reg.cnt_m1);
    assign pop      = (!busy_reg || job_done) && !q_status.empty;

    // Load the next job, step through its characters
    always_comb
    begin
        busy_next = busy_reg;
        job_next  = job_reg;
        idx_next  = idx_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            job_next  = pop_job;
            idx_next  = 2'd0;
        end
        else if (job_done)
            busy_next = 1'b0;
        else if (emit)
            idx_next = idx_reg + 2'd1;
    end

    // Fill the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = job_reg.chars[idx_reg];
            out_last_next  = job_reg.last && (idx_reg == job_reg.cnt_m1);
        end
        else if (advance)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tlast  = out_last_reg;

endmodule

### design/base64_stream_encoder.sv
// Base64 stream encoder: one byte in, one to four characters out.
// First character of a byte: through the queue entry, job register and output
// register. Throughput: one character per cycle on the output stage unless
// m_tready or an empty queue stalls it; 1 to 4 characters per byte, 4 per group.
// Reset (rst_n low, asynchronous): group phase, leftover bits, queue and
// output stage clear; the next byte starts a new group.
`timescale 1ns / 1ps

module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = b64e_pkg::B64E_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] char_code, [7] zero
    output logic        m_tlast    // last_char
);
    import b64e_pkg::*;

    logic            push, pop;
    b64e_job_t       push_job, pop_job;
    b64e_q_status_t  q_status;

    b64e_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .push     (push),
        .push_job (push_job),
        .q_status (q_status)
    );

    b64e_queue #(
        .Depth (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    b64e_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_status (q_status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### design/b64e_checker.sv
// Port-level checker for the Base64 stream encoder, bound to the top level.
// Depends on base64_stream_encoder_assert.svh for the assertion macros.
`timescale 1ns / 1ps
`include "base64_stream_encoder_assert.svh"

module b64e_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast
);

    // A stalled character stays offered
    `B64E_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)

    // A stalled character and its mark hold
    `B64E_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))

    // Characters are 7-bit ASCII
    `B64E_ASSERT_IMP(a_ascii, m_tvalid, m_tdata[7] == 1'b0)

    // Characters lie between '+' and 'z'
    `B64E_ASSERT_IMP(a_range, m_tvalid, (m_tdata[6:0] >= 7'd43) && (m_tdata[6:0] <= 7'd122))

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### tb/sv/tb_top.sv
// Self-checking testbench for the Base64 stream encoder: drives byte messages
// and checks every character against a predicted stream. Depends on b64e_pkg
// and base64_stream_encoder.
`timescale 1ns / 1ps

module tb_top;

    import b64e_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int BYTES_PER_RUN = 80;
    localparam int DRAIN_CYCLES  = 8;

    // One predicted output character
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } b64_char_t;

    // Predicts the character stream and compares it with what the block emits
    class base64_scoreboard;
        b64e_phase_t phase;
        logic [3:0]  leftover;
        b64_char_t   pending_chars[$];
        int          errors;
        int          chars_checked;

        function new();
            phase         = PH_FIRST;
            leftover      = 4'd0;
            errors        = 0;
            chars_checked = 0;
        endfunction

        // Map a sextet onto the standard alphabet
        function logic [CHAR_W-1:0] sextet_char(logic [5:0] s);
            logic [CHAR_W-1:0] c;
            if (s <= 6'd25)
                c = CHAR_W'("A" + {2'b00, s});
            else if (s <= 6'd51)
                c = CHAR_W'("a" + {2'b00, s - 6'd26});
            else if (s <= 6'd61)
                c = CHAR_W'("0" + {2'b00, s - 6'd52});
            else if (s == 6'd62)
                c = CHAR_W'("+");
            else
                c = CHAR_W'("/");
            return c;
        endfunction

        function void push_char(logic [CHAR_W-1:0] code, logic last);
            b64_char_t e;
            e.code = code;
            e.last = last;
            pending_chars.push_back(e);
        endfunction

        // Work out the characters caused by one accepted byte
        function void note_byte(logic [7:0] b, logic fin);
            case (phase)
                PH_SECOND:
                begin
                    push_char(sextet_char({leftover[1:0], b[7:4]}), 1'b0);
                    if (fin)
                    begin
                        push_char(sextet_char({b[3:0], 2'b00}), 1'b0);
                        push_char(PAD_CHAR, 1'b1);
                    end
                    else
                    begin
                        leftover = b[3:0];
                        phase    = PH_THIRD;
                    end
                end
                PH_THIRD:
                begin
                    push_char(sextet_char({leftover, b[7:6]}), 1'b0);
                    push_char(sextet_char(b[5:0]), fin);
                    leftover = 4'd0;
                    phase    = PH_FIRST;
                end
                default:
                begin
                    push_char(sextet_char(b[7:2]), 1'b0);
                    if (fin)
                    begin
                        push_char(sextet_char({b[1:0], 4'b0000}), 1'b0);
                        push_char(PAD_CHAR, 1'b0);
                        push_char(PAD_CHAR, 1'b1);
                    end
                    else
                    begin
                        leftover = {2'b00, b[1:0]};
                        phase    = PH_SECOND;
                    end
                end
            endcase
            // Start a new message after the last byte
            if (fin)
            begin
                phase    = PH_FIRST;
                leftover = 4'd0;
            end
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        // Compare one accepted character with the oldest prediction
        task check_char(logic [7:0] tdata, logic tlast);
            b64_char_t e;
            if (pending_chars.size() == 0)
            begin
                report($sformatf("unexpected character 0x%02h last=%0b", tdata, tlast));
            end
            else
            begin
                e = pending_chars.pop_front();
                chars_checked++;
                if (tdata !== {1'b0, e.code})
                    report($sformatf("char_code 0x%02h, predicted 0x%02h", tdata, e.code));
                if (tlast !== e.last)
                    report($sformatf("last_char %0b, predicted %0b", tlast, e.last));
            end
        endtask

        function int pending();
            return pending_chars.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;

    base64_stream_encoder i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    base64_scoreboard sb = new();

    int send_idle_pct;
    int recv_idle_pct;
    int bytes_sent;
    int messages_sent;
    int cycle_count;

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Check each character transfer and stall the output at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_char(m_tdata, m_tlast);
            m_tready <= (int'($urandom_range(99)) >= recv_idle_pct);
        end
    end

    // Offer one byte, idling first at random, and hold it until transfer
    task send_byte(input logic [7:0] b, input logic fin);
        while (int'($urandom_range(99)) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_byte(b, fin);
        bytes_sent++;
        if (fin)
            messages_sent++;
    endtask

    // Send a message of random bytes, mostly short ones
    task send_message(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)), i == len - 1);
    endtask

    task wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task run_random(input int send_pct, input int recv_pct);
        int start;
        int len;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start = bytes_sent;
        while (bytes_sent - start < BYTES_PER_RUN)
        begin
            if ($urandom_range(9) == 0)
                len = int'($urandom_range(10, 30));
            else
                len = int'($urandom_range(1, 9));
            send_message(len);
        end
    endtask

    // End the run at the cycle limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d characters outstanding",
                 cycle_count, sb.pending());
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n         <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= 8'd0;
        s_tlast       <= 1'b0;
        m_tready      <= 1'b0;
        send_idle_pct = 15;
        recv_idle_pct = 49;
        bytes_sent    = 0;
        messages_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one-byte messages at the byte extremes
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        // Message ending on the second byte of a group
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b1);
        // Full group followed by a one-byte tail
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        // Groups that map to '+' and '/' only
        send_byte(8'hfb, 1'b0);
        send_byte(8'hef, 1'b0);
        send_byte(8'hbe, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        // Plain text group that ends the message on a full group
        send_byte("M", 1'b0);
        send_byte("a", 1'b0);
        send_byte("n", 1'b1);

        // Hold the input until the output has caught up
        s_tvalid <= 1'b0;
        wait_drained();

        run_random(15, 49);
        s_tvalid <= 1'b0;
        wait_drained();

        run_random(49, 15);
        s_tvalid <= 1'b0;
        wait_drained();

        run_random(0, 0);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d messages, checked %0d characters",
                 bytes_sent, messages_sent, sb.chars_checked);
        $display("Covered last byte at every group position under input and output stalls");
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/b64e_pkg.sv
design/b64e_queue.sv
design/b64e_front.sv
design/b64e_back.sv
design/base64_stream_encoder.sv
design/b64e_checker.sv
tb/sv/tb_top.sv
